// ----- rtl/core/ellc_pkg.sv -----
// shared types and constants for the llc/snap header parser
// no dependencies
`timescale 1ns / 1ps

package ellc_pkg;

    localparam int unsigned CountW = 16;

    localparam logic [CountW-1:0] COUNT_MAX      = 16'hffff;
    localparam logic [CountW-1:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [CountW-1:0] LLC_END_BYTES  = 16'd17;
    localparam logic [CountW-1:0] SNAP_END_BYTES = 16'd22;
    localparam logic [CountW-1:0] DST_END        = 16'd6;
    localparam logic [CountW-1:0] SRC_END        = 16'd12;
    localparam logic [CountW-1:0] OUI_END        = 16'd20;
    localparam logic [15:0]       LLC_FIELD_LEN  = 16'd3;
    localparam logic [15:0]       LLC_SNAP_LEN   = 16'd8;
    localparam logic [15:0]       TYPE_MIN       = 16'h0600;
    localparam logic [15:0]       TYPE_IPV4      = 16'h0800;
    localparam logic [15:0]       TYPE_ARP       = 16'h0806;
    localparam logic [7:0]        SAP_STP        = 8'h42;
    localparam logic [7:0]        SAP_SNAP       = 8'haa;

    localparam logic [2:0] CLS_SHORT = 3'd0;
    localparam logic [2:0] CLS_IPV4  = 3'd1;
    localparam logic [2:0] CLS_ARP   = 3'd2;
    localparam logic [2:0] CLS_OTHER = 3'd3;
    localparam logic [2:0] CLS_STP   = 3'd4;
    localparam logic [2:0] CLS_SNAP  = 3'd5;
    localparam logic [2:0] CLS_LLC   = 3'd6;
    localparam logic [2:0] CLS_BAD   = 3'd7;

    // captured header of the frame in progress, including the current beat
    typedef struct packed {
        logic [CountW-1:0] flen;
        logic [47:0]       dst;
        logic [47:0]       src;
        logic [15:0]       etype;
        logic [23:0]       llc;
        logic [23:0]       oui;
        logic [15:0]       proto;
    } t_hdr;

    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [2:0]  frame_class;
        logic [7:0]  dsap;
        logic [7:0]  ssap;
        logic [7:0]  llc_control;
        logic [23:0] snap_oui;
        logic [15:0] snap_protocol;
        logic [15:0] payload_length;
        logic [15:0] frame_length;
    } t_record;

endpackage

// ----- rtl/core/ethernet_llc_snap_header_parser.sv -----
// top level: ethernet ii / 802.3 llc / snap header parser
// depends on ellc_pkg and ellc_classify
`timescale 1ns / 1ps

// Takes a frame one byte per beat from the destination MAC onward, with
// i_last_byte on the final byte, and emits one record per frame on the beat
// after the input register hands over the last byte. A byte is accepted every
// cycle as long as the output side keeps up; only a last byte waits in the
// input register, and only while the previous record is still held by a
// stalled output, with the next byte stalled behind it. The record path is one
// input register, the header capture and classifier logic, and one output
// register, loaded with the record as the last byte leaves the input register.
// Other bytes never wait there on the output side. Frame lengths count up to
// 65535 and stay there; header capture is not affected by length.

module ethernet_llc_snap_header_parser
    import ellc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_ether_type,
    output logic [2:0]  o_frame_class,
    output logic [7:0]  o_dsap,
    output logic [7:0]  o_ssap,
    output logic [7:0]  o_llc_control,
    output logic [23:0] o_snap_oui,
    output logic [15:0] o_snap_protocol,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_frame_length
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic [47:0]       r_dst;
    logic [47:0]       n_dst;
    logic [47:0]       r_src;
    logic [47:0]       n_src;
    logic [15:0]       r_type;
    logic [15:0]       n_type;
    logic [23:0]       r_llc;
    logic [23:0]       n_llc;
    logic [23:0]       r_oui;
    logic [23:0]       n_oui;
    logic [15:0]       r_proto;
    logic [15:0]       n_proto;
    logic              r_out_valid;
    t_record           r_out_rec;

    logic    w_out_free;
    logic    w_adv;
    logic    w_in_ready;
    logic    w_in_acc;
    t_hdr    w_hdr;
    t_record w_rec;

    assign w_out_free = !r_out_valid || !i_stall;
    // only the last beat of a frame needs room at the output
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign w_in_ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_valid && w_in_ready;
    assign o_stall    = !w_in_ready;

    always_comb begin
        n_dst   = r_dst;
        n_src   = r_src;
        n_type  = r_type;
        n_llc   = r_llc;
        n_oui   = r_oui;
        n_proto = r_proto;
        if (r_count < DST_END) begin
            n_dst = {r_dst[39:0], r_in_byte};
        end else if (r_count < SRC_END) begin
            n_src = {r_src[39:0], r_in_byte};
        end else if (r_count < ETH_HDR_BYTES) begin
            n_type = {r_type[7:0], r_in_byte};
        end else if (r_count < LLC_END_BYTES) begin
            n_llc = {r_llc[15:0], r_in_byte};
        end else if (r_count < OUI_END) begin
            n_oui = {r_oui[15:0], r_in_byte};
        end else if (r_count < SNAP_END_BYTES) begin
            n_proto = {r_proto[7:0], r_in_byte};
        end
        n_count = (r_count < COUNT_MAX) ? r_count + 1'b1 : COUNT_MAX;
    end

    always_comb begin
        w_hdr.flen  = n_count;
        w_hdr.dst   = n_dst;
        w_hdr.src   = n_src;
        w_hdr.etype = n_type;
        w_hdr.llc   = n_llc;
        w_hdr.oui   = n_oui;
        w_hdr.proto = n_proto;
    end

    ellc_classify u_classify (
        .i_hdr (w_hdr),
        .o_rec (w_rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // header bytes are always overwritten before the record reads them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_adv) begin
            r_count <= r_in_last ? '0 : n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dst   <= n_dst;
            r_src   <= n_src;
            r_type  <= n_type;
            r_llc   <= n_llc;
            r_oui   <= n_oui;
            r_proto <= n_proto;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_rec <= w_rec;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_dst_mac        = r_out_rec.dst_mac;
    assign o_src_mac        = r_out_rec.src_mac;
    assign o_ether_type     = r_out_rec.ether_type;
    assign o_frame_class    = r_out_rec.frame_class;
    assign o_dsap           = r_out_rec.dsap;
    assign o_ssap           = r_out_rec.ssap;
    assign o_llc_control    = r_out_rec.llc_control;
    assign o_snap_oui       = r_out_rec.snap_oui;
    assign o_snap_protocol  = r_out_rec.snap_protocol;
    assign o_payload_length = r_out_rec.payload_length;
    assign o_frame_length   = r_out_rec.frame_length;

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_count == '0))
        else $error("byte count not cleared after frame end");

    a_short_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rec.frame_class == CLS_SHORT) |->
        (r_out_rec.frame_length < ETH_HDR_BYTES && r_out_rec.dst_mac == '0 &&
         r_out_rec.payload_length == '0))
        else $error("short frame record carries header data");

    a_snap_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rec.frame_class == CLS_SNAP) |->
        (r_out_rec.frame_length >= SNAP_END_BYTES && r_out_rec.ether_type >= LLC_SNAP_LEN))
        else $error("snap record from a frame too short for its header");

    a_stall_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_in_last && r_out_valid))
        else $error("input stalled without a pending last beat");

endmodule

// ----- rtl/core/ellc_classify.sv -----
// frame classification and record build from the captured header
// depends on ellc_pkg
`timescale 1ns / 1ps

module ellc_classify
    import ellc_pkg::*;
(
    input  t_hdr    i_hdr,
    output t_record o_rec
);

    logic       w_have_llc;
    logic [7:0] w_dsap;
    logic [7:0] w_ssap;

    assign w_have_llc = (i_hdr.flen >= LLC_END_BYTES);
    assign w_dsap     = i_hdr.llc[23:16];
    assign w_ssap     = i_hdr.llc[15:8];

    always_comb begin
        o_rec = '0;
        o_rec.frame_length = i_hdr.flen;
        o_rec.frame_class  = CLS_SHORT;
        if (i_hdr.flen >= ETH_HDR_BYTES) begin
            o_rec.dst_mac    = i_hdr.dst;
            o_rec.src_mac    = i_hdr.src;
            o_rec.ether_type = i_hdr.etype;
            if (i_hdr.etype >= TYPE_MIN) begin
                if (i_hdr.etype == TYPE_IPV4) begin
                    o_rec.frame_class = CLS_IPV4;
                end else if (i_hdr.etype == TYPE_ARP) begin
                    o_rec.frame_class = CLS_ARP;
                end else begin
                    o_rec.frame_class = CLS_OTHER;
                end
                o_rec.payload_length = i_hdr.flen - ETH_HDR_BYTES;
            end else begin
                // llc bytes only count once all three have arrived
                if (w_have_llc) begin
                    o_rec.dsap        = w_dsap;
                    o_rec.ssap        = w_ssap;
                    o_rec.llc_control = i_hdr.llc[7:0];
                end
                if (!w_have_llc || i_hdr.etype < LLC_FIELD_LEN) begin
                    o_rec.frame_class = CLS_BAD;
                end else if (w_dsap == SAP_STP && w_ssap == SAP_STP) begin
                    o_rec.frame_class    = CLS_STP;
                    o_rec.payload_length = i_hdr.etype - LLC_FIELD_LEN;
                end else if (w_dsap == SAP_SNAP && w_ssap == SAP_SNAP) begin
                    if (i_hdr.flen >= SNAP_END_BYTES && i_hdr.etype >= LLC_SNAP_LEN) begin
                        o_rec.frame_class    = CLS_SNAP;
                        o_rec.snap_oui       = i_hdr.oui;
                        o_rec.snap_protocol  = i_hdr.proto;
                        o_rec.payload_length = i_hdr.etype - LLC_SNAP_LEN;
                    end else begin
                        o_rec.frame_class = CLS_BAD;
                    end
                end else begin
                    o_rec.frame_class    = CLS_LLC;
                    o_rec.payload_length = i_hdr.etype - LLC_FIELD_LEN;
                end
            end
        end
    end

endmodule
